/* src/tgce_pkg.sv */
`default_nettype none

package tgce_pkg;

	localparam int MAX_COLUMNS_DEF = 128;
	localparam int MAX_ROWS_DEF    = 64;
	localparam int TAB_STOP_DEF    = 8;
	localparam int COLS_RESET      = 80;
	localparam int ROWS_RESET      = 25;

	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] CH_BS      = 8'h08;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_ESC     = 8'h1B;

	localparam logic [1:0] FUNC_TYPE = 2'd0;
	localparam logic [1:0] FUNC_NAV  = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	localparam logic [7:0] KEY_HOME   = 8'd0;
	localparam logic [7:0] KEY_END    = 8'd1;
	localparam logic [7:0] KEY_PGUP   = 8'd2;
	localparam logic [7:0] KEY_PGDN   = 8'd3;
	localparam logic [7:0] KEY_LEFT   = 8'd4;
	localparam logic [7:0] KEY_RIGHT  = 8'd5;
	localparam logic [7:0] KEY_UP     = 8'd6;
	localparam logic [7:0] KEY_DOWN   = 8'd7;
	localparam logic [7:0] KEY_DELETE = 8'd8;

	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_PUT,
		OP_BS,
		OP_TAB,
		OP_LF,
		OP_CR,
		OP_ESC,
		OP_HOME,
		OP_END,
		OP_PGUP,
		OP_PGDN,
		OP_LEFT,
		OP_RIGHT,
		OP_UP,
		OP_DOWN,
		OP_DEL
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ_WAIT,
		ST_DEL_RD,
		ST_DEL_WR,
		ST_TAB_MOD,
		ST_TAB,
		ST_RESULT
	} back_state_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] key_code;
		logic [6:0] read_column;
		logic [5:0] read_row;
	} in_item_t;

	typedef struct packed {
		logic [6:0] caret_column;
		logic [5:0] caret_row;
		logic [7:0] read_char;
	} out_item_t;

	typedef struct packed {
		logic       is_read;
		op_t        op;
		logic [7:0] ch;
		logic [6:0] rc;
		logic [5:0] rr;
	} cmd_t;

	typedef struct packed {
		logic       we;
		logic       index;
		logic [7:0] data;
	} cfg_wr_t;

endpackage

`default_nettype wire

/* src/text_grid_caret_editor.sv */
`default_nettype none

// Character grid with a caret. Items queue in a two-beat command queue, run one at a time
// in the grid engine, and their results leave through a two-beat result queue. A typed
// character, navigation key or out-of-grid read goes straight to the result state; an
// in-grid read waits a state for the registered cell memory read. Delete and backspace
// shift the row left through the cell memory, reading and then writing each moved cell.
// Tab first reduces caret_column modulo TAB_STOP by repeated subtraction, then writes one
// space per step up to the next stop or the row end. Escape, a size register write and
// reset run a clearing pass over all MAX_COLUMNS*MAX_ROWS cells (8192 by default), one
// cell per cycle, with full held high; only escape gives a result after the pass.
module text_grid_caret_editor #(
	parameter int MAX_COLUMNS = tgce_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = tgce_pkg::MAX_ROWS_DEF,
	parameter int TAB_STOP    = tgce_pkg::TAB_STOP_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  tgce_pkg::in_item_t  item,
	output logic                empty,
	input  wire                 pop,
	output tgce_pkg::out_item_t result,
	input  wire                 cfg_we,
	input  wire                 cfg_index,
	input  wire  [7:0]          cfg_data
);
	import tgce_pkg::*;

	cmd_t      cmd;
	cfg_wr_t   cfg;
	out_item_t res_item;
	logic      cmd_valid, cmd_pop, clearing, res_push, res_full;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	tgce_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.clearing  (clearing),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	tgce_back #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS),
		.TAB_STOP    (TAB_STOP)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.clearing  (clearing),
		.res_push  (res_push),
		.res_item  (res_item),
		.res_full  (res_full)
	);

	tgce_out_q u_out_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_item (res_item),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

`ifndef SYNTHESIS
	a_no_res_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full) else $error("result beat pushed into a full queue");

	a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid) else $error("engine took a command from an empty queue");

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full) else $error("input open during clearing pass");
`endif

endmodule

`default_nettype wire

/* src/tgce_front.sv */
`default_nettype none

module tgce_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  tgce_pkg::in_item_t  item,
	input  wire                 clearing,
	output logic                cmd_valid,
	output tgce_pkg::cmd_t      cmd,
	input  wire                 cmd_pop
);
	import tgce_pkg::*;

	localparam logic [1:0] QDEPTH = 2'd2;

	cmd_t       cq_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       do_push;

	always_comb begin
		cls = '0;
		cls.op = OP_NONE;
		cls.ch = item.key_code;
		cls.rc = item.read_column;
		cls.rr = item.read_row;
		case (item.func)
			FUNC_TYPE: begin
				case (item.key_code)
					CH_BS:   cls.op = OP_BS;
					CH_TAB:  cls.op = OP_TAB;
					CH_LF:   cls.op = OP_LF;
					CH_CR:   cls.op = OP_CR;
					CH_ESC:  cls.op = OP_ESC;
					default: cls.op = OP_PUT;
				endcase
			end
			FUNC_NAV: begin
				case (item.key_code)
					KEY_HOME:   cls.op = OP_HOME;
					KEY_END:    cls.op = OP_END;
					KEY_PGUP:   cls.op = OP_PGUP;
					KEY_PGDN:   cls.op = OP_PGDN;
					KEY_LEFT:   cls.op = OP_LEFT;
					KEY_RIGHT:  cls.op = OP_RIGHT;
					KEY_UP:     cls.op = OP_UP;
					KEY_DOWN:   cls.op = OP_DOWN;
					KEY_DELETE: cls.op = OP_DEL;
					default:    cls.op = OP_NONE;
				endcase
			end
			FUNC_READ: cls.is_read = 1'b1;
			default:   cls.op = OP_NONE;
		endcase
	end

	assign full      = (cnt_q == QDEPTH) || clearing;
	assign do_push   = push && !full;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = cq_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			cq_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (cmd_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, cmd_pop};
		end
	end

endmodule

`default_nettype wire

/* src/tgce_back.sv */
`default_nettype none

module tgce_back #(
	parameter int MAX_COLUMNS = tgce_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = tgce_pkg::MAX_ROWS_DEF,
	parameter int TAB_STOP    = tgce_pkg::TAB_STOP_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  tgce_pkg::cfg_wr_t   cfg,
	input  wire                 cmd_valid,
	input  tgce_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	output logic                clearing,
	output logic                res_push,
	output tgce_pkg::out_item_t res_item,
	input  wire                 res_full
);
	import tgce_pkg::*;

	localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int NW    = $clog2(MAX_COLUMNS + 1);
	localparam int RNW   = $clog2(MAX_ROWS + 1);
	localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TW    = $clog2(TAB_STOP + 1);
	localparam int MW    = (CW > TW) ? CW : TW;
	localparam int COLS_INIT = (COLS_RESET > MAX_COLUMNS) ? MAX_COLUMNS : COLS_RESET;
	localparam int ROWS_INIT = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;

	back_state_t    state_q, state_d;
	logic [CW-1:0]  ccol_q, ccol_d, x_q, x_d;
	logic [RW-1:0]  crow_q, crow_d;
	logic [NW-1:0]  cols_q, cols_d;
	logic [RNW-1:0] rows_q, rows_d;
	logic [MW-1:0]  m_q, m_d;
	logic [AW-1:0]  clr_q, clr_d;
	logic           clr_res_q, clr_res_d;
	logic [7:0]     rchar_q, rchar_d;

	logic [7:0]     mem [DEPTH];
	logic [7:0]     rdata_q;
	logic           mem_we;
	logic [AW-1:0]  waddr, raddr;
	logic [7:0]     wdata;

	logic [CW:0]    col_inc, x_inc, cols_x;
	logic [RW:0]    row_inc, rows_x;
	logic [MW:0]    m_inc;
	logic           col_wrap, row_wrap, tab_hit, in_grid;
	logic [RW-1:0]  row_next;
	logic [CW-1:0]  last_col;
	logic [RW-1:0]  last_row;
	logic [AW-1:0]  caret_addr;

	function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c, input logic [RW-1:0] r);
		return AW'(r) * AW'(MAX_COLUMNS) + AW'(c);
	endfunction

	function automatic logic [NW-1:0] clamp_cols(input logic [7:0] v);
		if (v == 8'd0) begin
			return NW'(1);
		end else if (int'(v) > MAX_COLUMNS) begin
			return NW'(MAX_COLUMNS);
		end
		return NW'(v);
	endfunction

	function automatic logic [RNW-1:0] clamp_rows(input logic [6:0] v);
		if (v == 7'd0) begin
			return RNW'(1);
		end else if (int'(v) > MAX_ROWS) begin
			return RNW'(MAX_ROWS);
		end
		return RNW'(v);
	endfunction

	assign cols_x     = (CW + 1)'(cols_q);
	assign rows_x     = (RW + 1)'(rows_q);
	assign col_inc    = {1'b0, ccol_q} + (CW + 1)'(1);
	assign x_inc      = {1'b0, x_q} + (CW + 1)'(1);
	assign row_inc    = {1'b0, crow_q} + (RW + 1)'(1);
	assign col_wrap   = (col_inc >= cols_x);
	assign row_wrap   = (row_inc >= rows_x);
	assign row_next   = row_wrap ? '0 : RW'(row_inc);
	assign last_col   = CW'(cols_q - NW'(1));
	assign last_row   = RW'(rows_q - RNW'(1));
	assign m_inc      = {1'b0, m_q} + (MW + 1)'(1);
	assign tab_hit    = (m_inc == (MW + 1)'(TAB_STOP));
	assign caret_addr = cell_addr(ccol_q, crow_q);
	assign in_grid    = (int'(cmd.rc) < int'(cols_q)) && (int'(cmd.rr) < int'(rows_q));
	assign clearing   = (state_q == ST_CLEAR);

	assign res_item.caret_column = 7'(ccol_q);
	assign res_item.caret_row    = 6'(crow_q);
	assign res_item.read_char    = rchar_q;

	always_comb begin
		state_d   = state_q;
		ccol_d    = ccol_q;
		crow_d    = crow_q;
		cols_d    = cols_q;
		rows_d    = rows_q;
		x_d       = x_q;
		m_d       = m_q;
		clr_d     = clr_q;
		clr_res_d = clr_res_q;
		rchar_d   = rchar_q;
		mem_we    = 1'b0;
		waddr     = caret_addr;
		wdata     = SPACE_CHAR;
		raddr     = '0;
		cmd_pop   = 1'b0;
		res_push  = 1'b0;

		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				waddr  = clr_q;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = clr_res_q ? ST_RESULT : ST_IDLE;
				end else begin
					clr_d = clr_q + AW'(1);
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					rchar_d = 8'd0;
					state_d = ST_RESULT;
					if (cmd.is_read) begin
						if (in_grid) begin
							raddr   = cell_addr(CW'(cmd.rc), RW'(cmd.rr));
							state_d = ST_READ_WAIT;
						end else begin
							rchar_d = SPACE_CHAR;
						end
					end else begin
						case (cmd.op)
							OP_PUT: begin
								mem_we = 1'b1;
								wdata  = cmd.ch;
								if (col_wrap) begin
									ccol_d = '0;
									crow_d = row_next;
								end else begin
									ccol_d = CW'(col_inc);
								end
							end
							OP_BS: begin
								if (ccol_q != '0) begin
									ccol_d  = ccol_q - CW'(1);
									x_d     = ccol_q - CW'(1);
									state_d = ST_DEL_RD;
								end
							end
							OP_TAB: begin
								m_d     = MW'(ccol_q);
								state_d = ST_TAB_MOD;
							end
							OP_LF: crow_d = row_next;
							OP_CR: begin
								ccol_d = '0;
								crow_d = row_next;
							end
							OP_ESC: begin
								ccol_d    = '0;
								crow_d    = '0;
								clr_d     = '0;
								clr_res_d = 1'b1;
								state_d   = ST_CLEAR;
							end
							OP_HOME: ccol_d = '0;
							OP_END:  ccol_d = last_col;
							OP_PGUP: crow_d = '0;
							OP_PGDN: crow_d = last_row;
							OP_LEFT: begin
								if (ccol_q != '0) begin
									ccol_d = ccol_q - CW'(1);
								end
							end
							OP_RIGHT: begin
								if (!col_wrap) begin
									ccol_d = CW'(col_inc);
								end
							end
							OP_UP: begin
								if (crow_q != '0) begin
									crow_d = crow_q - RW'(1);
								end
							end
							OP_DOWN: begin
								if (!row_wrap) begin
									crow_d = RW'(row_inc);
								end
							end
							OP_DEL: begin
								x_d     = ccol_q;
								state_d = ST_DEL_RD;
							end
							default: state_d = ST_RESULT;
						endcase
					end
				end
			end
			ST_READ_WAIT: begin
				rchar_d = rdata_q;
				state_d = ST_RESULT;
			end
			ST_DEL_RD: begin
				if (x_inc < cols_x) begin
					raddr   = cell_addr(CW'(x_inc), crow_q);
					state_d = ST_DEL_WR;
				end else begin
					mem_we  = 1'b1;
					waddr   = cell_addr(x_q, crow_q);
					state_d = ST_RESULT;
				end
			end
			ST_DEL_WR: begin
				mem_we  = 1'b1;
				waddr   = cell_addr(x_q, crow_q);
				wdata   = rdata_q;
				x_d     = CW'(x_inc);
				state_d = ST_DEL_RD;
			end
			ST_TAB_MOD: begin
				if (m_q >= MW'(TAB_STOP)) begin
					m_d = m_q - MW'(TAB_STOP);
				end else begin
					state_d = ST_TAB;
				end
			end
			ST_TAB: begin
				mem_we = 1'b1;
				if (col_wrap) begin
					ccol_d  = '0;
					crow_d  = row_next;
					state_d = ST_RESULT;
				end else begin
					ccol_d = CW'(col_inc);
					if (tab_hit) begin
						state_d = ST_RESULT;
					end else begin
						m_d = MW'(m_inc);
					end
				end
			end
			ST_RESULT: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		if (cfg.we) begin
			if (cfg.index == REG_COLUMNS) begin
				cols_d = clamp_cols(cfg.data);
			end else begin
				rows_d = clamp_rows(cfg.data[6:0]);
			end
			ccol_d    = '0;
			crow_d    = '0;
			clr_d     = '0;
			clr_res_d = 1'b0;
			state_d   = ST_CLEAR;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		x_q     <= x_d;
		m_q     <= m_d;
		rchar_q <= rchar_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			ccol_q    <= '0;
			crow_q    <= '0;
			cols_q    <= NW'(COLS_INIT);
			rows_q    <= RNW'(ROWS_INIT);
			clr_q     <= '0;
			clr_res_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			ccol_q    <= ccol_d;
			crow_q    <= crow_d;
			cols_q    <= cols_d;
			rows_q    <= rows_d;
			clr_q     <= clr_d;
			clr_res_q <= clr_res_d;
		end
	end

endmodule

`default_nettype wire

/* src/tgce_out_q.sv */
`default_nettype none

module tgce_out_q (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 res_push,
	input  tgce_pkg::out_item_t res_item,
	output logic                res_full,
	output logic                empty,
	input  wire                 pop,
	output tgce_pkg::out_item_t result
);
	import tgce_pkg::*;

	localparam logic [1:0] QDEPTH = 2'd2;

	out_item_t  oq_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_pop;

	assign res_full = (cnt_q == QDEPTH);
	assign empty    = (cnt_q == 2'd0);
	assign do_pop   = pop && !empty;
	assign result   = oq_q[rp_q];

	always_ff @(posedge clk) begin
		if (res_push) begin
			oq_q[wp_q] <= res_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (res_push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, res_push} - {1'b0, do_pop};
		end
	end

endmodule

`default_nettype wire
